// ===== design/mam_pkg.sv =====
`timescale 1ns / 1ps

package mam_pkg;

  localparam int DEPTH_DEF = 6;
  localparam int SAMPLE_W  = 8;
  localparam int MAG_W     = 8;
  localparam int AXES      = 3;
  localparam int AXIS_W    = 2;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 capture;
    logic                 update;
    logic                 mul_en;
    axis_t                axis;
    logic                 acc_en;
    logic                 root_init;
    logic                 root_step;
    logic                 div_init;
    logic                 div_step;
    logic                 out_load;
  } cmd_t;

endpackage

// ===== design/mam_datapath.sv =====
`timescale 1ns / 1ps

module mam_datapath #(
  parameter int DEPTH = mam_pkg::DEPTH_DEF,
  parameter int SUM_W = $clog2(DEPTH * (2 ** (mam_pkg::SAMPLE_W - 1))) + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mam_pkg::cmd_t                 cmd,
  input  logic [mam_pkg::SAMPLE_W-1:0]  accel_x,
  input  logic [mam_pkg::SAMPLE_W-1:0]  accel_y,
  input  logic [mam_pkg::SAMPLE_W-1:0]  accel_z,
  output logic [mam_pkg::MAG_W-1:0]     magnitude
);

  localparam int SW      = mam_pkg::SAMPLE_W;
  localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W   = 2 * SUM_W;
  localparam int REM_W   = SUM_W + 2;
  localparam int DIV_SH  = SUM_W + $clog2(DEPTH);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** DIV_SH + DEPTH - 1) / DEPTH);

  // Sample rings, one per axis, with a valid bit per slot so that unwritten
  // entries read as zero after reset.
  logic [SW-1:0] ring_x [DEPTH];
  logic [SW-1:0] ring_y [DEPTH];
  logic [SW-1:0] ring_z [DEPTH];
  logic [DEPTH-1:0] slot_valid;
  logic [SLOT_W-1:0] slot;

  logic [SW-1:0] new_x, new_y, new_z;
  logic [SW-1:0] old_x, old_y, old_z;
  logic          old_ok;

  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic [SUM_W-1:0]        mul_a;
  logic [ACC_W-1:0]        prod, acc, acc_sum;

  logic [ACC_W-1:0] rad;
  logic [REM_W-1:0] rem, rem_sh, trial, rem_nx;
  logic [SUM_W-1:0] root, root_nx;
  logic             rge;

  logic [SUM_W-1:0]          drem;
  logic [PROD_W-1:0]         qprod;
  logic [mam_pkg::MAG_W-1:0] quot;

  function automatic logic signed [SUM_W-1:0] sext(input logic [SW-1:0] v);
    return signed'({{(SUM_W - SW){v[SW-1]}}, v});
  endfunction

  function automatic logic [SUM_W-1:0] absv(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      new_x <= accel_x;
      new_y <= accel_y;
      new_z <= accel_z;
      old_x <= ring_x[slot];
      old_y <= ring_y[slot];
      old_z <= ring_z[slot];
    end
    if (cmd.update) begin
      ring_x[slot] <= new_x;
      ring_y[slot] <= new_y;
      ring_z[slot] <= new_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot       <= '0;
      old_ok     <= 1'b0;
      sum_x      <= '0;
      sum_y      <= '0;
      sum_z      <= '0;
    end else begin
      if (cmd.capture) begin
        old_ok <= slot_valid[slot];
      end
      if (cmd.update) begin
        slot_valid[slot] <= 1'b1;
        slot  <= (slot == SLOT_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
        sum_x <= sum_x + sext(new_x) - (old_ok ? sext(old_x) : '0);
        sum_y <= sum_y + sext(new_y) - (old_ok ? sext(old_y) : '0);
        sum_z <= sum_z + sext(new_z) - (old_ok ? sext(old_z) : '0);
      end
    end
  end

  // One shared squarer; the three squares are summed over consecutive cycles.
  always_comb begin
    case (cmd.axis)
      mam_pkg::AXIS_X: mul_a = absv(sum_x);
      mam_pkg::AXIS_Y: mul_a = absv(sum_y);
      mam_pkg::AXIS_Z: mul_a = absv(sum_z);
      default:         mul_a = '0;
    endcase
  end

  assign acc_sum = acc + prod;

  // Restoring square root, one result bit per cycle.
  assign rem_sh  = {rem[SUM_W-1:0], rad[ACC_W-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign rge     = (rem_sh >= trial);
  assign rem_nx  = rge ? (rem_sh - trial) : rem_sh;
  assign root_nx = {root[SUM_W-2:0], rge};

  // Division by the window length as a multiply by the rounded-up reciprocal.
  // The root stays below 2^SUM_W, where this product gives the exact floor.
  assign qprod = PROD_W'(drem) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc_sum;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_a;
    end
    if (cmd.root_init) begin
      rad  <= acc_sum;
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad  <= rad << 2;
      rem  <= rem_nx;
      root <= root_nx;
    end
    if (cmd.div_init) begin
      drem <= root_nx;
    end else if (cmd.div_step) begin
      quot <= qprod[DIV_SH +: mam_pkg::MAG_W];
    end
    if (cmd.out_load) begin
      magnitude <= quot;
    end
  end

endmodule

// ===== design/mam_controller.sv =====
`timescale 1ns / 1ps

module mam_controller #(
  parameter int ROOT_STEPS = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output mam_pkg::cmd_t cmd
);

  localparam int CNT_W = $clog2(ROOT_STEPS);
  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(mam_pkg::AXES);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UPDATE = 6'b000010,
    S_SQUARE = 6'b000100,
    S_ROOT   = 6'b001000,
    S_DIVIDE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.axis       = mam_pkg::axis_t'(cnt[mam_pkg::AXIS_W-1:0]);
    case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        cnt_next   = '0;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        // Square of axis n is registered at count n and summed in the cycle after.
        cmd.mul_en = (cnt != SQ_LAST);
        cmd.acc_en = (cnt != '0) && (cnt != SQ_LAST);
        if (cnt == SQ_LAST) begin
          cmd.root_init = 1'b1;
          cnt_next      = '0;
          state_next    = S_ROOT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == ROOT_LAST) begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIVIDE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/accel_moving_average_magnitude.sv =====
`timescale 1ns / 1ps
// Moving-average magnitude of a three-axis accelerometer stream.
// Input channel: accel_x/y/z (signed 8-bit) with in_valid/in_ready; one
// transaction per sample. Output channel: magnitude (unsigned 8-bit) with
// out_valid/out_ready; exactly one result transaction per input transaction.
// The block keeps the last DEPTH samples per axis and a running sum per axis,
// and returns floor(isqrt(Sx^2 + Sy^2 + Sz^2) / DEPTH).
// One item is worked at a time, so a new sample is taken only once the last
// one is finished. The work is the bit-per-cycle square root (SUM_W result
// bits, SUM_W being 11 at DEPTH 6), the shared squarer that takes the three
// axes in turn and a multiply by the reciprocal of DEPTH.
// The output register holds a finished result while the receiver stalls, and
// the next sample is still accepted and worked; only when a second result is
// ready before the first is taken does the block wait, with in_ready low.
// Reset clears the controller, the running sums, the ring position and the
// per-slot valid bits, so the first windows average in zeros.
module accel_moving_average_magnitude #(
  parameter int DEPTH = mam_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mam_pkg::SAMPLE_W-1:0]  accel_x,
  input  logic [mam_pkg::SAMPLE_W-1:0]  accel_y,
  input  logic [mam_pkg::SAMPLE_W-1:0]  accel_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mam_pkg::MAG_W-1:0]     magnitude
);

  localparam int SUM_W = $clog2(DEPTH * (2 ** (mam_pkg::SAMPLE_W - 1))) + 1;

  mam_pkg::cmd_t cmd;

  mam_controller #(
    .ROOT_STEPS(SUM_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  mam_datapath #(
    .DEPTH(DEPTH),
    .SUM_W(SUM_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .accel_x  (accel_x),
    .accel_y  (accel_y),
    .accel_z  (accel_z),
    .magnitude(magnitude)
  );

  // A sample is worked over many cycles, so the input closes after a transaction.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a sample is in progress");

  // The windowed average vector never exceeds 221 in length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (magnitude <= 8'd221))
    else $error("magnitude out of range");

  // A new result appears only as the controller returns to waiting for input.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded outside the end of a computation");

endmodule

// ===== verif/magnitude_checker.sv =====
`timescale 1ns / 1ps

module magnitude_checker #(
  parameter int DEPTH = mam_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [mam_pkg::SAMPLE_W-1:0] accel_x,
  input  logic [mam_pkg::SAMPLE_W-1:0] accel_y,
  input  logic [mam_pkg::SAMPLE_W-1:0] accel_z,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [mam_pkg::MAG_W-1:0]    magnitude,
  output int                           mismatches,
  output int                           outstanding,
  output int                           checked,
  output logic [mam_pkg::MAG_W-1:0]    peak_magnitude
);
  localparam int SAMPLE_W = mam_pkg::SAMPLE_W;
  localparam int MAG_W    = mam_pkg::MAG_W;

  logic signed [SAMPLE_W-1:0] hist_x [DEPTH];
  logic signed [SAMPLE_W-1:0] hist_y [DEPTH];
  logic signed [SAMPLE_W-1:0] hist_z [DEPTH];
  int                         slot;
  int                         sum_x;
  int                         sum_y;
  int                         sum_z;
  logic [MAG_W-1:0]           pending_magnitudes [$];

  always @(posedge clk) begin
    logic [MAG_W-1:0] want;
    int unsigned      energy;
    int unsigned      root;
    int unsigned      trial;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist_x[i] = '0;
        hist_y[i] = '0;
        hist_z[i] = '0;
      end
      slot           = 0;
      sum_x          = 0;
      sum_y          = 0;
      sum_z          = 0;
      mismatches     = 0;
      checked        = 0;
      peak_magnitude = '0;
      pending_magnitudes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_magnitudes.size() == 0) begin
          $error("magnitude: unexpected result transaction, expected none, actual %0d",
                 magnitude);
          mismatches++;
        end else begin
          want = pending_magnitudes.pop_front();
          checked++;
          if (magnitude !== want) begin
            $error("magnitude mismatch: expected %0d, actual %0d", want, magnitude);
            mismatches++;
          end
          if (magnitude > peak_magnitude) peak_magnitude = magnitude;
        end
      end
      if (in_valid && in_ready) begin
        // The new sample replaces the oldest one in the window.
        sum_x = sum_x - int'(hist_x[slot]) + int'($signed(accel_x));
        sum_y = sum_y - int'(hist_y[slot]) + int'($signed(accel_y));
        sum_z = sum_z - int'(hist_z[slot]) + int'($signed(accel_z));
        hist_x[slot] = accel_x;
        hist_y[slot] = accel_y;
        hist_z[slot] = accel_z;
        slot = (slot == DEPTH - 1) ? 0 : slot + 1;
        energy = sum_x * sum_x + sum_y * sum_y + sum_z * sum_z;
        // Floor square root, one result bit at a time from the top.
        root = 0;
        for (int b = 15; b >= 0; b--) begin
          trial = root | (32'd1 << b);
          if (trial * trial <= energy) root = trial;
        end
        want = MAG_W'(root / DEPTH);
        pending_magnitudes.push_back(want);
      end
    end
    outstanding = pending_magnitudes.size();
  end

endmodule

// ===== verif/accel_moving_average_magnitude_test.sv =====
`timescale 1ns / 1ps

module accel_moving_average_magnitude_test;

  localparam int SAMPLE_W     = mam_pkg::SAMPLE_W;
  localparam int MAG_W        = mam_pkg::MAG_W;
  localparam int DEPTH_DEF    = mam_pkg::DEPTH_DEF;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_GAP      = 32;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] accel_x   = '0;
  logic [SAMPLE_W-1:0] accel_y   = '0;
  logic [SAMPLE_W-1:0] accel_z   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [MAG_W-1:0]    magnitude;

  int                  mismatches;
  int                  outstanding;
  int                  checked;
  logic [MAG_W-1:0]    peak_magnitude;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  samples_sent  = 0;

  always #5 clk = ~clk;

  accel_moving_average_magnitude #(
    .DEPTH(DEPTH_DEF)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .accel_x  (accel_x),
    .accel_y  (accel_y),
    .accel_z  (accel_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .magnitude(magnitude)
  );

  magnitude_checker #(
    .DEPTH(DEPTH_DEF)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .accel_x       (accel_x),
    .accel_y       (accel_y),
    .accel_z       (accel_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .magnitude     (magnitude),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .checked       (checked),
    .peak_magnitude(peak_magnitude)
  );

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Gaps are runs of several cycles so that they land anywhere in the busy window.
  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                             input logic [SAMPLE_W-1:0] z);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x  <= x;
    accel_y  <= y;
    accel_z  <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_axis(input int mode);
    if (mode < 50) return SAMPLE_W'($urandom_range(255));
    if (mode < 70) return SAMPLE_W'($urandom_range(16) - 8);
    if (mode < 85) begin
      case ($urandom_range(3))
        0:       return 8'h80;
        1:       return 8'h7f;
        2:       return 8'hff;
        default: return 8'h00;
      endcase
    end
    if ($urandom_range(1)) return SAMPLE_W'($urandom_range(255));
    return $urandom_range(1) ? 8'h80 : 8'h7f;
  endfunction

  initial begin
    int                  mode;
    int                  run_left;
    logic [SAMPLE_W-1:0] vx;
    logic [SAMPLE_W-1:0] vy;
    logic [SAMPLE_W-1:0] vz;
    run_left = 0;
    mode     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 46;
    // A full window of the most negative sample gives the largest vector.
    repeat (DEPTH_DEF) send_sample(8'h80, 8'h80, 8'h80);
    repeat (DEPTH_DEF) send_sample(8'h7f, 8'h7f, 8'h7f);
    send_sample(8'h80, 8'h7f, 8'h00);
    send_sample(8'h7f, 8'h80, 8'hff);
    send_sample(8'hff, 8'h01, 8'h80);
    send_sample(8'h01, 8'hff, 8'h7f);
    repeat (DEPTH_DEF) send_sample(8'h00, 8'h00, 8'h00);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 46;
        recv_idle_pct = 11;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Constant runs fill the whole window and reach the large magnitudes.
      if (run_left == 0) begin
        mode     = $urandom_range(99);
        run_left = (mode >= 85) ? $urandom_range(DEPTH_DEF, 2 * DEPTH_DEF) : 1;
        vx       = random_axis(mode);
        vy       = random_axis(mode);
        vz       = random_axis(mode);
      end
      send_sample(vx, vy, vz);
      run_left--;
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples and checked %0d magnitudes under three stall patterns.",
             samples_sent, checked);
    $display("Largest magnitude seen: %0d, mismatches: %0d, left waiting: %0d.",
             peak_magnitude, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Watchdog: no transaction for %0d cycles.", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
